>>> sv/fbri_pkg.sv
// Package for the framebuffer register and interrupt block.
// Holds register offsets, item codes, reset values and shared structs; no dependencies.
package fbri_pkg;

    localparam int OfsW = 10;

    localparam logic [OfsW-1:0] OFS_WIDTH       = 10'h000;
    localparam logic [OfsW-1:0] OFS_HEIGHT      = 10'h004;
    localparam logic [OfsW-1:0] OFS_STATUS      = 10'h008;
    localparam logic [OfsW-1:0] OFS_ENABLE      = 10'h00c;
    localparam logic [OfsW-1:0] OFS_BASE        = 10'h010;
    localparam logic [OfsW-1:0] OFS_ROTATION    = 10'h014;
    localparam logic [OfsW-1:0] OFS_BLANK       = 10'h018;
    localparam logic [OfsW-1:0] OFS_PHYS_WIDTH  = 10'h01c;
    localparam logic [OfsW-1:0] OFS_PHYS_HEIGHT = 10'h020;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;
    localparam logic [1:0] ACT_INVAL = 2'd3;

    localparam int BIT_VSYNC = 0;
    localparam int BIT_DONE  = 1;

    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_PHYS_WIDTH   = 2'd2;
    localparam logic [1:0] CFG_PHYS_HEIGHT  = 2'd3;

    localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd320;
    localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam int InDataW  = 48;
    localparam int OutDataW = 72;

    typedef struct packed {
        logic [11:0] frame_width;
        logic [11:0] frame_height;
        logic [15:0] width_mm;
        logic [15:0] height_mm;
    } cfg_t;

    typedef struct packed {
        logic [31:0] frame_base;
        logic        blank_active;
        logic        full_refresh;
        logic [1:0]  current_rotation;
        logic        rotate_request;
        logic        bad_offset;
        logic        irq_level;
        logic [31:0] read_data;
    } res_t;

endpackage

>>> sv/fbri_cfg.sv
// APB configuration registers of the framebuffer register block.
// Depends on fbri_pkg for register indexes, reset values and cfg_t.
module fbri_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output fbri_pkg::cfg_t      cfg
);

    fbri_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= fbri_pkg::FRAME_WIDTH_RESET;
            cfg_reg.frame_height <= fbri_pkg::FRAME_HEIGHT_RESET;
            cfg_reg.width_mm     <= 16'd0;
            cfg_reg.height_mm    <= 16'd0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                fbri_pkg::CFG_FRAME_WIDTH:  cfg_reg.frame_width  <= pwdata[11:0];
                fbri_pkg::CFG_FRAME_HEIGHT: cfg_reg.frame_height <= pwdata[11:0];
                fbri_pkg::CFG_PHYS_WIDTH:   cfg_reg.width_mm     <= pwdata[15:0];
                fbri_pkg::CFG_PHYS_HEIGHT:  cfg_reg.height_mm    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            fbri_pkg::CFG_FRAME_WIDTH:  prdata = {20'd0, cfg_reg.frame_width};
            fbri_pkg::CFG_FRAME_HEIGHT: prdata = {20'd0, cfg_reg.frame_height};
            fbri_pkg::CFG_PHYS_WIDTH:   prdata = {16'd0, cfg_reg.width_mm};
            fbri_pkg::CFG_PHYS_HEIGHT:  prdata = {16'd0, cfg_reg.height_mm};
            default:                    prdata = 32'd0;
        endcase
    end

endmodule

>>> sv/fbri_core.sv
// Controller state and per-word decode of the framebuffer register block.
// Depends on fbri_pkg for offsets, item codes, cfg_t and res_t.
module fbri_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [1:0]          action,
    input  logic [9:0]          reg_offset,
    input  logic [31:0]         write_data,
    input  fbri_pkg::cfg_t      cfg,
    output fbri_pkg::res_t      res
);

    logic [1:0]  status_reg, status_next;
    logic [1:0]  enable_reg, enable_next;
    logic [31:0] base_reg, base_next;
    logic        seen_reg, seen_next;
    logic        refresh_reg, refresh_next;
    logic        done_pend_reg, done_pend_next;
    logic [1:0]  pend_rot_reg, pend_rot_next;
    logic [1:0]  rot_reg, rot_next;
    logic        blank_reg, blank_next;
    logic        irq_reg, irq_next;

    logic [31:0] rdata;
    logic [1:0]  hit;
    logic        bad;
    logic        rot_req;
    logic        full;

    always_comb
    begin
        status_next    = status_reg;
        enable_next    = enable_reg;
        base_next      = base_reg;
        seen_next      = seen_reg;
        refresh_next   = refresh_reg;
        done_pend_next = done_pend_reg;
        pend_rot_next  = pend_rot_reg;
        rot_next       = rot_reg;
        blank_next     = blank_reg;
        irq_next       = irq_reg;
        rdata          = 32'd0;
        bad            = 1'b0;
        rot_req        = 1'b0;
        full           = 1'b0;
        hit            = status_reg & enable_reg;

        case (action)
            fbri_pkg::ACT_READ:
            begin
                case (reg_offset)
                    fbri_pkg::OFS_WIDTH:       rdata = {20'd0, cfg.frame_width};
                    fbri_pkg::OFS_HEIGHT:      rdata = {20'd0, cfg.frame_height};
                    fbri_pkg::OFS_PHYS_WIDTH:  rdata = {16'd0, cfg.width_mm};
                    fbri_pkg::OFS_PHYS_HEIGHT: rdata = {16'd0, cfg.height_mm};
                    fbri_pkg::OFS_STATUS:
                    begin
                        rdata = {30'd0, hit};
                        if (hit != 2'b00)
                        begin
                            status_next = status_reg & ~hit;
                            irq_next    = 1'b0;
                        end
                    end
                    default: bad = 1'b1;
                endcase
            end
            fbri_pkg::ACT_WRITE:
            begin
                case (reg_offset)
                    fbri_pkg::OFS_ENABLE:
                    begin
                        enable_next = write_data[1:0];
                        irq_next    = (status_reg & write_data[1:0]) != 2'b00;
                    end
                    fbri_pkg::OFS_BASE:
                    begin
                        rot_req                       = !seen_reg;
                        base_next                     = write_data;
                        status_next[fbri_pkg::BIT_DONE] = 1'b0;
                        refresh_next                  = 1'b1;
                        done_pend_next                = 1'b1;
                        seen_next                     = 1'b1;
                        if (pend_rot_reg != rot_reg)
                        begin
                            rot_next = pend_rot_reg;
                            rot_req  = 1'b1;
                        end
                        irq_next = (status_next & enable_reg) != 2'b00;
                    end
                    fbri_pkg::OFS_ROTATION: pend_rot_next = write_data[1:0];
                    fbri_pkg::OFS_BLANK:
                    begin
                        blank_next   = write_data[0];
                        refresh_next = 1'b1;
                    end
                    default: bad = 1'b1;
                endcase
            end
            fbri_pkg::ACT_TICK:
            begin
                if (base_reg != 32'd0)
                begin
                    if (enable_reg[fbri_pkg::BIT_VSYNC] && !status_reg[fbri_pkg::BIT_VSYNC])
                    begin
                        status_next[fbri_pkg::BIT_VSYNC] = 1'b1;
                        irq_next                         = 1'b1;
                    end
                    if (refresh_reg)
                    begin
                        full = 1'b1;
                        if (done_pend_reg)
                        begin
                            status_next[fbri_pkg::BIT_DONE] = 1'b1;
                            if (enable_reg[fbri_pkg::BIT_DONE])
                            begin
                                irq_next = 1'b1;
                            end
                        end
                        done_pend_next = 1'b0;
                        refresh_next   = 1'b0;
                    end
                end
            end
            fbri_pkg::ACT_INVAL: refresh_next = 1'b1;
            default: ;
        endcase

        res.read_data        = rdata;
        res.irq_level        = irq_next;
        res.bad_offset       = bad;
        res.rotate_request   = rot_req;
        res.current_rotation = rot_next;
        res.full_refresh     = full;
        res.blank_active     = blank_next;
        res.frame_base       = base_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg    <= 2'b00;
            enable_reg    <= 2'b00;
            base_reg      <= 32'd0;
            seen_reg      <= 1'b0;
            refresh_reg   <= 1'b0;
            done_pend_reg <= 1'b0;
            pend_rot_reg  <= 2'd0;
            rot_reg       <= 2'd0;
            blank_reg     <= 1'b0;
            irq_reg       <= 1'b0;
        end
        else if (advance)
        begin
            status_reg    <= status_next;
            enable_reg    <= enable_next;
            base_reg      <= base_next;
            seen_reg      <= seen_next;
            refresh_reg   <= refresh_next;
            done_pend_reg <= done_pend_next;
            pend_rot_reg  <= pend_rot_next;
            rot_reg       <= rot_next;
            blank_reg     <= blank_next;
            irq_reg       <= irq_next;
        end
    end

endmodule

>>> sv/framebuffer_register_interrupt_block.sv
// Top level of the framebuffer register and interrupt block: stream ports and pipeline registers.
// Depends on fbri_pkg, fbri_cfg and fbri_core.
//
// Each input word (a bus read, a bus write, a refresh tick or an invalidate) is captured in an
// input register, decoded against the controller state, and its result word is held in an
// output register; one word is accepted per clock unless the result side stalls, which holds
// both registers and stops acceptance while the input register is full. The result word
// reaches the output through the input register and then the output register. The user must
// set the display sizes through the APB port only while no word is in flight; the block does
// not enforce this. The sizes reset to 320 by 480 pixels and zero millimetres.
module framebuffer_register_interrupt_block (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // reg_offset[9:0], write_data[41:10], zero fill above.
    input  logic [fbri_pkg::InDataW-1:0]  s_tdata,
    // action[1:0].
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_data[31:0], irq_level[32], bad_offset[33], rotate_request[34],
    // current_rotation[36:35], full_refresh[37], blank_active[38], frame_base[70:39], zero[71].
    output logic [fbri_pkg::OutDataW-1:0] m_tdata
);

    fbri_pkg::cfg_t cfg;
    fbri_pkg::res_t res;

    logic        in_valid_reg;
    logic [1:0]  action_reg;
    logic [9:0]  offset_reg;
    logic [31:0] wdata_reg;
    logic        out_valid_reg;
    fbri_pkg::res_t out_reg;
    logic        advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    fbri_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fbri_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .action     (action_reg),
        .reg_offset (offset_reg),
        .write_data (wdata_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            action_reg <= s_tuser;
            offset_reg <= s_tdata[9:0];
            wdata_reg  <= s_tdata[41:10];
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for framebuffer_register_interrupt_block.
// Drives stream words and APB writes, predicts each result word, and checks it.
// Depends on fbri_pkg and the block's RTL.
`timescale 1ns / 100ps

module testbench;

    class FbRegShadow;
        fbri_pkg::cfg_t cfg;
        logic [1:0]     status;
        logic [1:0]     enables;
        logic [1:0]     pend_rot;
        logic [1:0]     applied_rot;
        logic [31:0]    base;
        bit             base_seen;
        bit             refresh_pending;
        bit             done_pending;
        bit             blank;
        bit             irq;
        fbri_pkg::res_t expected_words[$];
        int             mismatches;

        function new();
            cfg.frame_width = fbri_pkg::FRAME_WIDTH_RESET;
            cfg.frame_height = fbri_pkg::FRAME_HEIGHT_RESET;
            cfg.width_mm = '0;
            cfg.height_mm = '0;
            status = '0;
            enables = '0;
            pend_rot = '0;
            applied_rot = '0;
            base = '0;
            base_seen = 0;
            refresh_pending = 0;
            done_pending = 0;
            blank = 0;
            irq = 0;
            mismatches = 0;
        endfunction

        function void set_config(logic [1:0] idx, logic [31:0] value);
            case (idx)
                fbri_pkg::CFG_FRAME_WIDTH:  cfg.frame_width = value[11:0];
                fbri_pkg::CFG_FRAME_HEIGHT: cfg.frame_height = value[11:0];
                fbri_pkg::CFG_PHYS_WIDTH:   cfg.width_mm = value[15:0];
                default:                    cfg.height_mm = value[15:0];
            endcase
        endfunction

        function fbri_pkg::res_t predict_word(logic [1:0] act, logic [9:0] ofs,
                                              logic [31:0] data);
            fbri_pkg::res_t r;
            logic [1:0]     hit;
            r = '0;
            case (act)
                fbri_pkg::ACT_READ:
                    case (ofs)
                        fbri_pkg::OFS_WIDTH:       r.read_data = {20'd0, cfg.frame_width};
                        fbri_pkg::OFS_HEIGHT:      r.read_data = {20'd0, cfg.frame_height};
                        fbri_pkg::OFS_PHYS_WIDTH:  r.read_data = {16'd0, cfg.width_mm};
                        fbri_pkg::OFS_PHYS_HEIGHT: r.read_data = {16'd0, cfg.height_mm};
                        fbri_pkg::OFS_STATUS:
                        begin
                            hit = status & enables;
                            r.read_data = {30'd0, hit};
                            if (hit != 2'b00)
                            begin
                                status = status & ~hit;
                                irq = 0;
                            end
                        end
                        default:                   r.bad_offset = 1'b1;
                    endcase
                fbri_pkg::ACT_WRITE:
                    case (ofs)
                        fbri_pkg::OFS_ENABLE:
                        begin
                            enables = data[1:0];
                            irq = (status & enables) != 2'b00;
                        end
                        fbri_pkg::OFS_BASE:
                        begin
                            r.rotate_request = !base_seen;
                            base = data;
                            status[fbri_pkg::BIT_DONE] = 1'b0;
                            refresh_pending = 1;
                            done_pending = 1;
                            base_seen = 1;
                            if (pend_rot != applied_rot)
                            begin
                                applied_rot = pend_rot;
                                r.rotate_request = 1'b1;
                            end
                            irq = (status & enables) != 2'b00;
                        end
                        fbri_pkg::OFS_ROTATION:    pend_rot = data[1:0];
                        fbri_pkg::OFS_BLANK:
                        begin
                            blank = data[0];
                            refresh_pending = 1;
                        end
                        default:                   r.bad_offset = 1'b1;
                    endcase
                fbri_pkg::ACT_TICK:
                    if (base != 32'd0)
                    begin
                        if (enables[fbri_pkg::BIT_VSYNC] && !status[fbri_pkg::BIT_VSYNC])
                        begin
                            status[fbri_pkg::BIT_VSYNC] = 1'b1;
                            irq = 1;
                        end
                        if (refresh_pending)
                        begin
                            r.full_refresh = 1'b1;
                            if (done_pending)
                            begin
                                status[fbri_pkg::BIT_DONE] = 1'b1;
                                if (enables[fbri_pkg::BIT_DONE])
                                    irq = 1;
                            end
                            done_pending = 0;
                            refresh_pending = 0;
                        end
                    end
                default:
                    refresh_pending = 1;
            endcase
            r.irq_level = irq;
            r.current_rotation = applied_rot;
            r.blank_active = blank;
            r.frame_base = base;
            return r;
        endfunction

        function void accept_word(logic [1:0] act, logic [9:0] ofs, logic [31:0] data);
            expected_words.push_back(predict_word(act, ofs, data));
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: mismatch on %s: got 0x%h, expected 0x%h", $time, what, got, want);
            mismatches++;
        endtask

        task check_word(fbri_pkg::res_t got);
            fbri_pkg::res_t want;
            if (expected_words.size() == 0)
            begin
                report("unexpected result word", got.read_data, 32'd0);
                return;
            end
            want = expected_words.pop_front();
            if (got.read_data !== want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.irq_level !== want.irq_level)
                report("irq_level", got.irq_level, want.irq_level);
            if (got.bad_offset !== want.bad_offset)
                report("bad_offset", got.bad_offset, want.bad_offset);
            if (got.rotate_request !== want.rotate_request)
                report("rotate_request", got.rotate_request, want.rotate_request);
            if (got.current_rotation !== want.current_rotation)
                report("current_rotation", got.current_rotation, want.current_rotation);
            if (got.full_refresh !== want.full_refresh)
                report("full_refresh", got.full_refresh, want.full_refresh);
            if (got.blank_active !== want.blank_active)
                report("blank_active", got.blank_active, want.blank_active);
            if (got.frame_base !== want.frame_base)
                report("frame_base", got.frame_base, want.frame_base);
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [3:0]                    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [fbri_pkg::InDataW-1:0]  s_tdata;
    logic [1:0]                    s_tuser;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [fbri_pkg::OutDataW-1:0] m_tdata;

    FbRegShadow sb = new();
    bit         steady;

    framebuffer_register_interrupt_block dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial
    begin
        int n;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid === 1'b1 && m_tready)
            sb.check_word(fbri_pkg::res_t'(m_tdata[70:0]));
    end

    task automatic send_word(input logic [1:0] act, input logic [9:0] ofs,
                             input logic [31:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {6'd0, data, ofs};
        do
            @(posedge clk);
        while (!s_tready);
        sb.accept_word(act, ofs, data);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] want;
        want = (idx == fbri_pkg::CFG_FRAME_WIDTH || idx == fbri_pkg::CFG_FRAME_HEIGHT) ?
               (value & 32'h0000_0fff) : (value & 32'h0000_ffff);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_config(idx, value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            sb.report("prdata", prdata, want);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [9:0] pick_offset(input logic [1:0] act);
        if ($urandom_range(0, 9) == 0)
            return 10'($urandom);
        if (act == fbri_pkg::ACT_READ)
            case ($urandom_range(0, 4))
                0:       return fbri_pkg::OFS_WIDTH;
                1:       return fbri_pkg::OFS_HEIGHT;
                2:       return fbri_pkg::OFS_PHYS_WIDTH;
                3:       return fbri_pkg::OFS_PHYS_HEIGHT;
                default: return fbri_pkg::OFS_STATUS;
            endcase
        case ($urandom_range(0, 3))
            0:       return fbri_pkg::OFS_ENABLE;
            1:       return fbri_pkg::OFS_BASE;
            2:       return fbri_pkg::OFS_ROTATION;
            default: return fbri_pkg::OFS_BLANK;
        endcase
    endfunction

    task automatic send_random_word();
        int          r;
        logic [1:0]  act;
        logic [9:0]  ofs;
        logic [31:0] data;
        r = $urandom_range(0, 99);
        if (r < 30)
            act = fbri_pkg::ACT_READ;
        else if (r < 65)
            act = fbri_pkg::ACT_WRITE;
        else if (r < 90)
            act = fbri_pkg::ACT_TICK;
        else
            act = fbri_pkg::ACT_INVAL;
        ofs = (act == fbri_pkg::ACT_READ || act == fbri_pkg::ACT_WRITE) ?
              pick_offset(act) : 10'($urandom);
        data = $urandom;
        if (act == fbri_pkg::ACT_WRITE && ofs == fbri_pkg::OFS_BASE &&
            $urandom_range(0, 9) == 0)
            data = 32'd0;
        send_word(act, ofs, data);
    endtask

    task automatic run_phase(input logic [31:0] w, input logic [31:0] h,
                             input logic [31:0] pw, input logic [31:0] ph, input int count);
        apb_write_reg(fbri_pkg::CFG_FRAME_WIDTH, w);
        apb_write_reg(fbri_pkg::CFG_FRAME_HEIGHT, h);
        apb_write_reg(fbri_pkg::CFG_PHYS_WIDTH, pw);
        apb_write_reg(fbri_pkg::CFG_PHYS_HEIGHT, ph);
        steady = ($urandom_range(0, 3) == 0);
        repeat (count) send_random_word();
        wait_idle();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= fbri_pkg::ACT_READ;
        steady = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed words: reset sizes, bad offsets, the tick and status paths.
        send_word(fbri_pkg::ACT_READ, fbri_pkg::OFS_WIDTH, 32'd0);
        send_word(fbri_pkg::ACT_READ, fbri_pkg::OFS_HEIGHT, 32'd0);
        send_word(fbri_pkg::ACT_READ, fbri_pkg::OFS_PHYS_WIDTH, 32'd0);
        send_word(fbri_pkg::ACT_READ, fbri_pkg::OFS_PHYS_HEIGHT, 32'd0);
        send_word(fbri_pkg::ACT_READ, fbri_pkg::OFS_STATUS, 32'd0);
        send_word(fbri_pkg::ACT_TICK, 10'h3ff, 32'hffff_ffff);
        send_word(fbri_pkg::ACT_WRITE, 10'h3ff, 32'hffff_ffff);
        send_word(fbri_pkg::ACT_WRITE, 10'h00d, 32'h1234_5678);
        send_word(fbri_pkg::ACT_READ, fbri_pkg::OFS_ENABLE, 32'd0);
        send_word(fbri_pkg::ACT_READ, 10'h3fc, 32'd0);
        send_word(fbri_pkg::ACT_WRITE, fbri_pkg::OFS_ENABLE, 32'hffff_ffff);
        send_word(fbri_pkg::ACT_WRITE, fbri_pkg::OFS_ROTATION, 32'hffff_fffe);
        send_word(fbri_pkg::ACT_WRITE, fbri_pkg::OFS_BASE, 32'hffff_ffff);
        send_word(fbri_pkg::ACT_TICK, 10'd0, 32'd0);
        send_word(fbri_pkg::ACT_TICK, 10'd0, 32'd0);
        send_word(fbri_pkg::ACT_READ, fbri_pkg::OFS_STATUS, 32'd0);
        send_word(fbri_pkg::ACT_WRITE, fbri_pkg::OFS_BLANK, 32'hffff_ffff);
        send_word(fbri_pkg::ACT_TICK, 10'h155, 32'h5555_5555);
        send_word(fbri_pkg::ACT_INVAL, 10'h2aa, 32'haaaa_aaaa);
        send_word(fbri_pkg::ACT_TICK, 10'd0, 32'd0);
        send_word(fbri_pkg::ACT_WRITE, fbri_pkg::OFS_BASE, 32'd0);
        send_word(fbri_pkg::ACT_TICK, 10'd0, 32'd0);
        send_word(fbri_pkg::ACT_WRITE, fbri_pkg::OFS_ENABLE, 32'd0);
        send_word(fbri_pkg::ACT_READ, fbri_pkg::OFS_STATUS, 32'd0);
        send_word(fbri_pkg::ACT_WRITE, fbri_pkg::OFS_BLANK, 32'hffff_fffe);
        wait_idle();

        run_phase(32'd320, 32'd480, 32'd0, 32'd0, 186);
        run_phase(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 186);
        run_phase(32'd0, 32'd0, 32'd0, 32'd0, 186);
        run_phase($urandom, $urandom, $urandom, $urandom, 186);
        run_phase($urandom, $urandom, $urandom, $urandom, 186);

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
